/* hw/rtl/fmv_pkg.sv */
// Types, constants and field tables shared by the FM voice parameter store.
// Depends on nothing; every other file of the block but fmv_mem imports it.
package fmv_pkg;

    // Voice image geometry.
    localparam int VOICE_BYTES    = 128;
    localparam int ADDR_W         = 7;
    localparam int OPERATORS      = 6;
    localparam int OPERATOR_BYTES = 17;
    localparam int OP_PARAMS      = 21;
    localparam int VOICE_PARAMS   = 19;

    // Parameter spaces.
    localparam logic SPACE_OPERATOR = 1'b0;
    localparam logic SPACE_VOICE    = 1'b1;

    // Access kinds carried by one input word.
    typedef enum logic [1:0] {
        MODE_GET    = 2'd0,
        MODE_SET    = 2'd1,
        MODE_RAW_WR = 2'd2,
        MODE_RAW_RD = 2'd3
    } mode_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Placement and limits of one packed field.
    typedef struct packed {
        logic [ADDR_W-1:0] byte_ofs;
        logic [2:0]        shift;
        logic [7:0]        mask;
        logic [7:0]        cap;
        logic signed [5:0] bias;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
    } field_desc_t;

    // Decoded request for one word.
    typedef struct packed {
        mode_t             mode;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        field_desc_t       desc;
    } req_t;

    function automatic field_desc_t fd(
        input logic [ADDR_W-1:0] b,
        input logic [2:0]        s,
        input logic [7:0]        m,
        input logic [7:0]        c,
        input logic signed [5:0] bias,
        input logic signed [7:0] lo,
        input logic signed [7:0] hi
    );
        field_desc_t d;
        d.byte_ofs = b;
        d.shift    = s;
        d.mask     = m;
        d.cap      = c;
        d.bias     = bias;
        d.lo       = lo;
        d.hi       = hi;
        return d;
    endfunction

    // Operator fields; the byte offset is relative to the operator's base.
    function automatic field_desc_t op_field(input logic [4:0] pid);
        field_desc_t d;
        d = fd(7'd0, 3'd0, 8'h00, 8'd0, 6'sd0, 8'sd0, 8'sd0);
        unique case (pid) inside
            [5'd0:5'd7]: d = fd({2'b00, pid}, 3'd0, 8'hFF, 8'd99, 6'sd0, 8'sd0, 8'sd99);
            5'd8:  d = fd(7'd14, 3'd0, 8'hFF, 8'd99, 6'sd0, 8'sd0, 8'sd99);
            5'd9:  d = fd(7'd15, 3'd1, 8'h1F, 8'h1F, 6'sd0, 8'sd0, 8'sd31);
            5'd10: d = fd(7'd16, 3'd0, 8'hFF, 8'd99, 6'sd0, 8'sd0, 8'sd99);
            5'd11: d = fd(7'd12, 3'd3, 8'h0F, 8'h0F, -6'sd7, -8'sd7, 8'sd7);
            5'd12: d = fd(7'd12, 3'd0, 8'h07, 8'h07, 6'sd0, 8'sd0, 8'sd7);
            5'd13: d = fd(7'd13, 3'd2, 8'h07, 8'h07, 6'sd0, 8'sd0, 8'sd7);
            5'd14: d = fd(7'd13, 3'd0, 8'h03, 8'h03, 6'sd0, 8'sd0, 8'sd3);
            5'd15: d = fd(7'd15, 3'd0, 8'h01, 8'h01, 6'sd0, 8'sd0, 8'sd1);
            5'd16: d = fd(7'd8,  3'd0, 8'hFF, 8'd99, 6'sd0, 8'sd0, 8'sd99);
            5'd17: d = fd(7'd9,  3'd0, 8'hFF, 8'd99, 6'sd0, 8'sd0, 8'sd99);
            5'd18: d = fd(7'd10, 3'd0, 8'hFF, 8'd99, 6'sd0, 8'sd0, 8'sd99);
            5'd19: d = fd(7'd11, 3'd0, 8'h03, 8'h03, 6'sd0, 8'sd0, 8'sd3);
            5'd20: d = fd(7'd11, 3'd2, 8'h03, 8'h03, 6'sd0, 8'sd0, 8'sd3);
            default: d = fd(7'd0, 3'd0, 8'h00, 8'd0, 6'sd0, 8'sd0, 8'sd0);
        endcase
        return d;
    endfunction

    // Voice-wide fields; the byte offset is absolute.
    function automatic field_desc_t voice_field(input logic [4:0] pid);
        field_desc_t d;
        d = fd(7'd0, 3'd0, 8'h00, 8'd0, 6'sd0, 8'sd0, 8'sd0);
        unique case (pid) inside
            [5'd0:5'd7]: d = fd(7'd102 + {4'b0000, pid[2:0]}, 3'd0, 8'hFF, 8'd99,
                                6'sd0, 8'sd0, 8'sd99);
            5'd8:  d = fd(7'd110, 3'd0, 8'h1F, 8'h1F, 6'sd1, 8'sd1, 8'sd32);
            5'd9:  d = fd(7'd111, 3'd0, 8'h07, 8'h07, 6'sd0, 8'sd0, 8'sd7);
            5'd10: d = fd(7'd111, 3'd3, 8'h01, 8'h01, 6'sd0, 8'sd0, 8'sd1);
            5'd11: d = fd(7'd112, 3'd0, 8'hFF, 8'd99, 6'sd0, 8'sd0, 8'sd99);
            5'd12: d = fd(7'd113, 3'd0, 8'hFF, 8'd99, 6'sd0, 8'sd0, 8'sd99);
            5'd13: d = fd(7'd114, 3'd0, 8'hFF, 8'd99, 6'sd0, 8'sd0, 8'sd99);
            5'd14: d = fd(7'd115, 3'd0, 8'hFF, 8'd99, 6'sd0, 8'sd0, 8'sd99);
            5'd15: d = fd(7'd116, 3'd0, 8'h01, 8'h01, 6'sd0, 8'sd0, 8'sd1);
            5'd16: d = fd(7'd116, 3'd1, 8'h07, 8'd5,  6'sd0, 8'sd0, 8'sd5);
            5'd17: d = fd(7'd116, 3'd4, 8'h07, 8'h07, 6'sd0, 8'sd0, 8'sd7);
            5'd18: d = fd(7'd117, 3'd0, 8'hFF, 8'd48, -6'sd24, -8'sd24, 8'sd24);
            default: d = fd(7'd0, 3'd0, 8'h00, 8'd0, 6'sd0, 8'sd0, 8'sd0);
        endcase
        return d;
    endfunction

    // First byte of each operator: operator 5 comes first in the image.
    function automatic logic [ADDR_W-1:0] op_base(input logic [2:0] opn);
        logic [ADDR_W-1:0] b;
        b = '0;
        unique case (opn)
            3'd0:    b = 7'd85;
            3'd1:    b = 7'd68;
            3'd2:    b = 7'd51;
            3'd3:    b = 7'd34;
            3'd4:    b = 7'd17;
            default: b = 7'd0;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/fmv_mem.sv */
// Single-port synchronous byte memory holding the packed voice image.
// One access per cycle; read data is registered. Uses no package items.
module fmv_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          re,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write has priority; a read updates the output register only when issued.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/fmv_decode.sv */
// Decodes one input word into an access kind, a byte address and a field descriptor.
// Depends on fmv_pkg for the field tables and the request struct.
module fmv_decode
    import fmv_pkg::*;
(
    input  logic [1:0]        mode,
    input  logic              param_space,
    input  logic [2:0]        operator_index,
    input  logic [4:0]        param_id,
    input  logic [ADDR_W-1:0] byte_address,
    output req_t              req
);

    field_desc_t op_desc;
    field_desc_t vc_desc;
    logic        op_ok;
    logic        vc_ok;

    // Table lookups and range checks for both parameter spaces.
    always_comb
    begin
        op_desc = op_field(param_id);
        vc_desc = voice_field(param_id);
        op_ok   = (operator_index < 3'(OPERATORS)) && (param_id < 5'(OP_PARAMS));
        vc_ok   = param_id < 5'(VOICE_PARAMS);
    end

    // Select address and descriptor by access kind and space.
    always_comb
    begin
        req.mode = mode_t'(mode);
        req.hit  = 1'b1;
        req.addr = byte_address;
        req.desc = op_desc;
        unique case (mode_t'(mode)) inside
            MODE_GET, MODE_SET:
            begin
                if (param_space == SPACE_VOICE)
                begin
                    req.hit  = vc_ok;
                    req.desc = vc_desc;
                    req.addr = vc_desc.byte_ofs;
                end
                else
                begin
                    req.hit  = op_ok;
                    req.desc = op_desc;
                    req.addr = op_base(operator_index) + op_desc.byte_ofs;
                end
            end
            MODE_RAW_WR, MODE_RAW_RD:
            begin
                req.hit  = 1'b1;
                req.addr = byte_address;
            end
            default:
            begin
                req.hit = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/fmv_field.sv */
// Field unpack for reads and clamp-and-merge for writes of one voice byte.
// Depends on fmv_pkg for the field descriptor type.
module fmv_field
    import fmv_pkg::*;
(
    input  field_desc_t       desc,
    input  logic [7:0]        rdata,
    input  logic signed [8:0] value,
    output logic signed [8:0] get_value,
    output logic [7:0]        merged
);

    logic [7:0]        shifted;
    logic [7:0]        raw;
    logic [7:0]        capped;
    logic signed [8:0] bias9;
    logic signed [8:0] lo9;
    logic signed [8:0] hi9;
    logic signed [8:0] clamped;
    logic signed [8:0] unbiased;
    logic [7:0]        fmask;
    logic [7:0]        fld;

    // Read side: shift, mask, saturate, then apply the field's bias.
    always_comb
    begin
        shifted   = rdata >> desc.shift;
        raw       = shifted & desc.mask;
        capped    = (raw > desc.cap) ? desc.cap : raw;
        bias9     = signed'({{3{desc.bias[5]}}, desc.bias});
        get_value = signed'({1'b0, capped}) + bias9;
    end

    // Write side: clamp to range, remove the bias and merge into the byte.
    always_comb
    begin
        lo9 = signed'({desc.lo[7], desc.lo});
        hi9 = signed'({desc.hi[7], desc.hi});
        if (value < lo9)
        begin
            clamped = lo9;
        end
        else if (value > hi9)
        begin
            clamped = hi9;
        end
        else
        begin
            clamped = value;
        end
        unbiased = clamped - bias9;
        fld      = (unbiased[7:0] & desc.mask) << desc.shift;
        fmask    = desc.mask << desc.shift;
        merged   = (rdata & ~fmask) | fld;
    end

endmodule

/* hw/rtl/fm_voice_param_store.sv */
// FM voice parameter store: holds one 128-byte packed voice in a single-port byte
// memory and serves one word per request: get or set a named operator or voice
// parameter, or write or read a raw byte. The accept cycle issues the memory read;
// the execute state unpacks or merges the field, writes the byte back for a set or
// raw write, and loads the result register. The execute state waits while the
// previous result is still held; the single memory port and the result register
// take one word at a time: no word is accepted before the last is done. The memory
// has no reset; bytes read before they were ever written return undefined data.
// Depends on fmv_pkg, fmv_decode, fmv_field and fmv_mem.
module fm_voice_param_store
    import fmv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic              param_space,
    input  logic [2:0]        operator_index,
    input  logic [4:0]        param_id,
    input  logic signed [8:0] value,
    input  logic [6:0]        byte_address,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [8:0] read_value,
    output logic              ok
);

    state_t            state_reg;
    state_t            state_next;
    req_t              dec_req;
    req_t              req_reg;
    logic signed [8:0] value_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic signed [8:0] read_value_reg;
    logic signed [8:0] read_value_next;
    logic              ok_reg;
    logic              accept;
    logic              done;
    logic              mem_re;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;
    logic signed [8:0] get_value;
    logic [7:0]        merged;

    fmv_decode u_decode (
        .mode           (mode),
        .param_space    (param_space),
        .operator_index (operator_index),
        .param_id       (param_id),
        .byte_address   (byte_address),
        .req            (dec_req)
    );

    fmv_field u_field (
        .desc      (req_reg.desc),
        .rdata     (mem_rdata),
        .value     (value_reg),
        .get_value (get_value),
        .merged    (merged)
    );

    fmv_mem #(
        .DEPTH (VOICE_BYTES)
    ) u_mem (
        .clk   (clk),
        .re    (mem_re),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer: read in the accept cycle, write back and respond in the execute state.
    // The read and write of one word never share a cycle, and the next word is
    // read only after the write, so no forwarding is needed.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                done = !out_valid_reg || out_ready;
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // Memory port control.
    always_comb
    begin
        mem_re    = accept;
        mem_addr  = (state_reg == ST_EXEC) ? req_reg.addr : dec_req.addr;
        mem_we    = done && ((req_reg.mode == MODE_RAW_WR) ||
                             ((req_reg.mode == MODE_SET) && req_reg.hit));
        mem_wdata = (req_reg.mode == MODE_RAW_WR) ? value_reg[7:0] : merged;
    end

    // Capture the decoded word at accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= dec_req;
            value_reg <= value;
        end
    end

    // Result value for the word in flight.
    always_comb
    begin
        read_value_next = '0;
        unique case (req_reg.mode)
            MODE_GET:    read_value_next = req_reg.hit ? get_value : 9'sd0;
            MODE_RAW_RD: read_value_next = signed'({1'b0, mem_rdata});
            default:     read_value_next = '0;
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            read_value_reg <= read_value_next;
            ok_reg         <= req_reg.hit;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign ok         = ok_reg;

    // An accepted word always moves the sequencer to its execute cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted word did not enter execute");

    // The memory is written only in the execute cycle, never alongside a read.
    a_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_EXEC) && !mem_re)
        else $error("memory write outside execute cycle");

    // A failed access always reports a zero value.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> read_value == 9'sd0)
        else $error("failed access returned a nonzero value");

endmodule

/* test/fmv_checker.sv */
// Scoreboard for the FM voice parameter store: watches both channels, keeps its own copy of
// the 128-byte voice image and compares every result word with the predicted one.
// Depends on fmv_pkg for the access modes, the parameter spaces and the voice geometry.
`timescale 1ns / 100ps

module fmv_checker
    import fmv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        mode,
    input  logic              param_space,
    input  logic [2:0]        operator_index,
    input  logic [4:0]        param_id,
    input  logic signed [8:0] value,
    input  logic [6:0]        byte_address,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic signed [8:0] read_value,
    input  logic              ok,
    output int                mismatches,
    output int                pending
);

    // Placement, read saturation, bias and legal range of one packed field.
    typedef struct packed {
        logic       hit;
        logic [6:0] ofs;
        logic [2:0] shift;
        logic [7:0] mask;
        logic [7:0] cap;
        int         bias;
        int         lo;
        int         hi;
    } field_t;

    // One predicted result word.
    typedef struct packed {
        logic signed [8:0] rd_val;
        logic              rd_ok;
    } reply_t;

    logic [7:0] voice_image [0:VOICE_BYTES-1];
    reply_t     expected_replies [$];
    int         results_seen;

    function automatic field_t shape(input int ofs, input int sh, input int msk, input int cap,
                                     input int bias, input int lo, input int hi);
        field_t f;
        f.hit   = 1'b1;
        f.ofs   = 7'(ofs);
        f.shift = 3'(sh);
        f.mask  = 8'(msk);
        f.cap   = 8'(cap);
        f.bias  = bias;
        f.lo    = lo;
        f.hi    = hi;
        return f;
    endfunction

    // A full byte that reads back saturated at 99.
    function automatic field_t level(input int ofs);
        return shape(ofs, 0, 8'hFF, 99, 0, 0, 99);
    endfunction

    // Field layout for a parameter; hit stays low for a bad operator or parameter.
    function automatic field_t lookup(input logic sp, input logic [2:0] opn,
                                      input logic [4:0] pid);
        field_t f;
        f     = level(0);
        f.hit = 1'b0;
        if (sp == SPACE_OPERATOR) begin
            if (int'(opn) < OPERATORS) begin
                case (pid)
                    5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7:
                        f = level(int'(pid));                   // EG rates and levels
                    5'd8:  f = level(14);                       // output level
                    5'd9:  f = shape(15, 1, 8'h1F, 8'h1F, 0, 0, 31);   // coarse
                    5'd10: f = level(16);                       // fine
                    5'd11: f = shape(12, 3, 8'h0F, 8'h0F, -7, -7, 7);  // detune
                    5'd12: f = shape(12, 0, 8'h07, 8'h07, 0, 0, 7);    // rate scaling
                    5'd13: f = shape(13, 2, 8'h07, 8'h07, 0, 0, 7);    // velocity sens
                    5'd14: f = shape(13, 0, 8'h03, 8'h03, 0, 0, 3);    // amp-mod sens
                    5'd15: f = shape(15, 0, 8'h01, 8'h01, 0, 0, 1);    // osc mode
                    5'd16: f = level(8);                        // breakpoint
                    5'd17: f = level(9);                        // left depth
                    5'd18: f = level(10);                       // right depth
                    5'd19: f = shape(11, 0, 8'h03, 8'h03, 0, 0, 3);    // left curve
                    5'd20: f = shape(11, 2, 8'h03, 8'h03, 0, 0, 3);    // right curve
                    default: f.hit = 1'b0;
                endcase
            end
        end else begin
            case (pid)
                5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7:
                    f = level(102 + int'(pid));                 // pitch EG
                5'd8:  f = shape(110, 0, 8'h1F, 8'h1F, 1, 1, 32);      // algorithm
                5'd9:  f = shape(111, 0, 8'h07, 8'h07, 0, 0, 7);       // feedback
                5'd10: f = shape(111, 3, 8'h01, 8'h01, 0, 0, 1);       // osc key sync
                5'd11: f = level(112);                          // LFO speed
                5'd12: f = level(113);                          // LFO delay
                5'd13: f = level(114);                          // pitch-mod depth
                5'd14: f = level(115);                          // amp-mod depth
                5'd15: f = shape(116, 0, 8'h01, 8'h01, 0, 0, 1);       // LFO key sync
                5'd16: f = shape(116, 1, 8'h07, 5, 0, 0, 5);           // LFO waveform
                5'd17: f = shape(116, 4, 8'h07, 8'h07, 0, 0, 7);       // pitch-mod sens
                5'd18: f = shape(117, 0, 8'hFF, 48, -24, -24, 24);     // transpose
                default: f.hit = 1'b0;
            endcase
        end
        return f;
    endfunction

    // Performs one accepted word on the image and returns the result it must give.
    function automatic reply_t apply_word(input logic [1:0] m_bits, input logic sp,
                                          input logic [2:0] opn, input logic [4:0] pid,
                                          input logic signed [8:0] val,
                                          input logic [6:0] addr);
        reply_t r;
        field_t f;
        int     a;
        int     raw;
        int     v;
        int     sel;
        r.rd_val = '0;
        r.rd_ok  = 1'b0;
        case (mode_t'(m_bits))
            MODE_RAW_WR:
            begin
                voice_image[addr] = val[7:0];
                r.rd_ok = 1'b1;
            end
            MODE_RAW_RD:
            begin
                r.rd_val = {1'b0, voice_image[addr]};
                r.rd_ok  = 1'b1;
            end
            default:
            begin
                f = lookup(sp, opn, pid);
                if (f.hit) begin
                    a = int'(f.ofs);
                    if (sp == SPACE_OPERATOR)
                        a = a + (OPERATORS - 1 - int'(opn)) * OPERATOR_BYTES;
                    if (mode_t'(m_bits) == MODE_GET) begin
                        raw = (int'(voice_image[a]) >> f.shift) & int'(f.mask);
                        if (raw > int'(f.cap))
                            raw = int'(f.cap);
                        r.rd_val = 9'(raw + f.bias);
                    end else begin
                        // Clamp, strip the bias and merge into the byte.
                        v = int'(val);
                        if (v < f.lo)
                            v = f.lo;
                        if (v > f.hi)
                            v = f.hi;
                        sel = int'(f.mask) << f.shift;
                        voice_image[a] = 8'((int'(voice_image[a]) & ~sel)
                                            | (((v - f.bias) & int'(f.mask)) << f.shift));
                    end
                    r.rd_ok = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // Results are compared before the word accepted at the same edge is queued.
    always @(posedge clk or negedge rst_n) begin
        reply_t want;
        if (!rst_n) begin
            expected_replies.delete();
            for (int i = 0; i < VOICE_BYTES; i++)
                voice_image[i] = 8'h00;
            mismatches   = 0;
            results_seen = 0;
            pending      = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_replies.size() == 0) begin
                    if (mismatches < 10)
                        $display("result word %0d arrived with none outstanding: %0d ok %0d",
                                 results_seen, read_value, ok);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    if (read_value !== want.rd_val || ok !== want.rd_ok) begin
                        if (mismatches < 10)
                            $display("result word %0d: read_value exp %0d got %0d, ok exp %0d got %0d",
                                     results_seen, want.rd_val, read_value, want.rd_ok, ok);
                        mismatches++;
                    end
                end
                results_seen++;
            end
            if (in_valid && in_ready)
                expected_replies.push_back(apply_word(mode, param_space, operator_index,
                                                      param_id, value, byte_address));
            pending = expected_replies.size();
        end
    end

endmodule

/* test/tb.sv */
// Top of the testbench for fm_voice_param_store: clock, reset, word stimulus with bursts and
// gaps, a stalling result receiver, and the verdict. Needs fmv_pkg, the DUT and fmv_checker.
`timescale 1ns / 100ps

module tb;
    import fmv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 800;

    // Parameter numbers used by the directed words.
    localparam logic [4:0] PID_EG_RATE1  = 5'd0;
    localparam logic [4:0] PID_COARSE    = 5'd9;
    localparam logic [4:0] PID_DETUNE    = 5'd11;
    localparam logic [4:0] PID_ALGORITHM = 5'd8;
    localparam logic [4:0] PID_FEEDBACK  = 5'd9;
    localparam logic [4:0] PID_LFO_WAVE  = 5'd16;
    localparam logic [4:0] PID_TRANSPOSE = 5'd18;
    localparam logic [4:0] PID_OP_BAD    = 5'd21;
    localparam logic [4:0] PID_VOICE_BAD = 5'd19;
    localparam logic [4:0] PID_TOP       = 5'd31;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        mode;
    logic              param_space;
    logic [2:0]        operator_index;
    logic [4:0]        param_id;
    logic signed [8:0] value;
    logic [6:0]        byte_address;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic signed [8:0] read_value;
    logic              ok;

    int mismatches;
    int pending;
    int cycles = 0;
    int burst_left;
    int ready_style = 0;
    int ready_left = 0;

    fm_voice_param_store i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .param_space    (param_space),
        .operator_index (operator_index),
        .param_id       (param_id),
        .value          (value),
        .byte_address   (byte_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_value     (read_value),
        .ok             (ok)
    );

    fmv_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .param_space    (param_space),
        .operator_index (operator_index),
        .param_id       (param_id),
        .value          (value),
        .byte_address   (byte_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_value     (read_value),
        .ok             (ok),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    always #5 clk = ~clk;

    // Hard stop in case a word or a result never gets through.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver switches at random among four stall styles: always ready, random, mostly stalled and alternating.
    always @(negedge clk) begin
        if (ready_left == 0) begin
            ready_style <= $urandom_range(0, 3);
            ready_left  <= $urandom_range(20, 120);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ~out_ready;
        endcase
    end

    // Presents one word at a falling edge and returns at the falling edge after acceptance.
    // Before a short burst the sender drops valid for a random gap; a long burst follows without one.
    task automatic send_word(input mode_t m, input logic sp, input logic [2:0] opn,
                             input logic [4:0] pid, input logic signed [8:0] val,
                             input logic [6:0] addr);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(30, 60);
            end else begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 7);
            end
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid       <= 1'b1;
        mode           <= m;
        param_space    <= sp;
        operator_index <= opn;
        param_id       <= pid;
        value          <= val;
        byte_address   <= addr;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Holds the sender off until every outstanding result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Random word: mostly legal parameter and raw byte accesses, with bad operators, bad
    // parameters and out-of-range values mixed in.
    task automatic send_random();
        mode_t             m;
        logic              sp;
        logic [2:0]        opn;
        logic [4:0]        pid;
        logic signed [8:0] val;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            m = MODE_GET;
        else if (pick < 70)
            m = MODE_SET;
        else if (pick < 85)
            m = MODE_RAW_WR;
        else
            m = MODE_RAW_RD;
        sp  = 1'($urandom_range(0, 1));
        opn = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, OPERATORS - 1))
                                           : 3'($urandom_range(OPERATORS, 7));
        if ($urandom_range(0, 99) < 85)
            pid = 5'($urandom_range(0, (sp == SPACE_OPERATOR) ? OP_PARAMS - 1
                                                               : VOICE_PARAMS - 1));
        else
            pid = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 1) == 0)
            val = 9'($urandom_range(0, 511));
        else
            val = 9'(int'($urandom_range(0, 140)) - 30);
        send_word(m, sp, opn, pid, val, 7'($urandom_range(0, VOICE_BYTES - 1)));
    endtask

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_GET;
        param_space    = SPACE_OPERATOR;
        operator_index = '0;
        param_id       = '0;
        value          = '0;
        byte_address   = '0;
        burst_left     = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Load the whole image first so that no access ever reads an unwritten byte.
        for (int a = 0; a < VOICE_BYTES; a++)
            send_word(MODE_RAW_WR, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      5'($urandom_range(0, 31)), 9'($urandom_range(0, 511)), 7'(a));

        // Directed words: saturation, clamping at both ends, biases and every error path.
        send_word(MODE_RAW_WR, SPACE_OPERATOR, 3'd0, PID_EG_RATE1, 9'sd255, 7'd85);
        send_word(MODE_GET, SPACE_OPERATOR, 3'd0, PID_EG_RATE1, 9'sd0, 7'd0);
        send_word(MODE_SET, SPACE_OPERATOR, 3'd5, PID_DETUNE, -9'sd256, 7'd0);
        send_word(MODE_GET, SPACE_OPERATOR, 3'd5, PID_DETUNE, 9'sd0, 7'd0);
        send_word(MODE_SET, SPACE_OPERATOR, 3'd5, PID_DETUNE, 9'sd255, 7'd0);
        send_word(MODE_GET, SPACE_OPERATOR, 3'd5, PID_DETUNE, 9'sd0, 7'd0);
        send_word(MODE_SET, SPACE_VOICE, 3'd0, PID_ALGORITHM, 9'sd0, 7'd0);
        send_word(MODE_GET, SPACE_VOICE, 3'd0, PID_ALGORITHM, 9'sd0, 7'd0);
        send_word(MODE_SET, SPACE_VOICE, 3'd0, PID_ALGORITHM, 9'sd32, 7'd0);
        send_word(MODE_GET, SPACE_VOICE, 3'd0, PID_ALGORITHM, 9'sd0, 7'd0);
        send_word(MODE_RAW_WR, SPACE_VOICE, 3'd0, PID_TOP, 9'sd200, 7'd117);
        send_word(MODE_GET, SPACE_VOICE, 3'd0, PID_TRANSPOSE, 9'sd0, 7'd0);
        send_word(MODE_SET, SPACE_VOICE, 3'd0, PID_TRANSPOSE, -9'sd100, 7'd0);
        send_word(MODE_GET, SPACE_VOICE, 3'd0, PID_TRANSPOSE, 9'sd0, 7'd0);
        send_word(MODE_RAW_WR, SPACE_OPERATOR, 3'd7, PID_TOP, 9'sd255, 7'd116);
        send_word(MODE_GET, SPACE_VOICE, 3'd0, PID_LFO_WAVE, 9'sd0, 7'd0);
        send_word(MODE_GET, SPACE_OPERATOR, 3'd6, PID_EG_RATE1, 9'sd0, 7'd0);
        send_word(MODE_SET, SPACE_OPERATOR, 3'd7, PID_COARSE, 9'sd10, 7'd0);
        send_word(MODE_GET, SPACE_OPERATOR, 3'd0, PID_OP_BAD, 9'sd0, 7'd0);
        send_word(MODE_SET, SPACE_VOICE, 3'd0, PID_VOICE_BAD, 9'sd5, 7'd0);
        send_word(MODE_GET, SPACE_VOICE, 3'd7, PID_TOP, 9'sd0, 7'd0);
        // The operator number does not matter in the voice space.
        send_word(MODE_GET, SPACE_VOICE, 3'd7, PID_FEEDBACK, 9'sd0, 7'd0);
        send_word(MODE_SET, SPACE_OPERATOR, 3'd0, PID_COARSE, 9'sd255, 7'd0);
        send_word(MODE_RAW_RD, SPACE_VOICE, 3'd7, PID_TOP, -9'sd256, 7'd0);
        send_word(MODE_RAW_RD, SPACE_OPERATOR, 3'd0, PID_EG_RATE1, 9'sd0, 7'd127);
        drain();

        // Random words, with one full drain halfway through.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            send_random();
            if (n == RANDOM_WORDS / 2)
                drain();
        end

        // Wait for the last results and for anything stray, then give the verdict.
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
